// File: src/rfr_pkg.sv
`default_nettype none

package rfr_pkg;

    localparam int MAX_PAYLOAD_BYTES = 3;
    localparam int PAYLOAD_W         = 8 * MAX_PAYLOAD_BYTES;
    localparam int CFG_ADDR_W        = 3;
    localparam int CFG_DATA_W        = 16;

    typedef enum logic [1:0] {
        CMD_ARM  = 2'd0,
        CMD_BYTE = 2'd1,
        CMD_TICK = 2'd2,
        CMD_RSVD = 2'd3
    } cmd_t;

    localparam logic [1:0] ST_GOOD    = 2'd0;
    localparam logic [1:0] ST_BADSUM  = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_START_CODE    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_EXP_COMMAND   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_EXP_LENGTH    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BYTE_TIMEOUT  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_TOTAL_TIMEOUT = 3'd4;

    localparam logic [7:0]  RST_START_CODE    = 8'd170;
    localparam logic [7:0]  RST_EXP_COMMAND   = 8'd1;
    localparam logic [1:0]  RST_EXP_LENGTH    = 2'd1;
    localparam logic [15:0] RST_BYTE_TIMEOUT  = 16'd100;
    localparam logic [15:0] RST_TOTAL_TIMEOUT = 16'd500;

    typedef struct packed {
        logic [7:0]  start_code;
        logic [7:0]  expected_command;
        logic [1:0]  expected_length;
        logic [15:0] byte_timeout_ticks;
        logic [15:0] total_timeout_ticks;
    } cfg_t;

endpackage

`default_nettype wire

// File: src/reply_frame_receiver.sv
// Channel  | Ports                        | Beat
// input    | s_valid s_ready              | s_command, s_rx_byte
// result   | m_valid m_ready              | m_status, m_payload
// config   | cfg_we                       | cfg_addr, cfg_wdata
//
// One beat per cycle while no result is stalled. An accepted beat is held in the
// input register, the frame state updates from it, and any result lands in the
// output register.
// While a result waits on m_ready, the beat in the input register waits too;
// s_ready then stays high only while the input register is empty.
// Synchronous active-low reset: idle, disarmed, config at defaults.
`default_nettype none

module reply_frame_receiver
    import rfr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output wire logic                  s_ready,
    input  wire logic [1:0]            s_command,
    input  wire logic [7:0]            s_rx_byte,
    output wire logic                  m_valid,
    input  wire logic                  m_ready,
    output wire logic [1:0]            m_status,
    output wire logic [PAYLOAD_W-1:0]  m_payload,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t cfg;

    rfr_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .cfg      (cfg)
    );

    // input register
    logic       in_valid_reg;
    cmd_t       in_cmd_reg;
    logic [7:0] in_byte_reg;

    // frame state
    logic                 armed_reg,   armed_next;
    logic [2:0]           pos_reg,     pos_next;
    logic [7:0]           sum_reg,     sum_next;
    logic [PAYLOAD_W-1:0] acc_reg,     acc_next;
    logic [15:0]          gap_reg,     gap_next;
    logic [15:0]          elapsed_reg, elapsed_next;

    // output register
    logic                 m_valid_reg,   m_valid_next;
    logic [1:0]           m_status_reg,  m_status_next;
    logic [PAYLOAD_W-1:0] m_payload_reg, m_payload_next;

    logic proc_go;
    logic emit;
    logic good;
    logic bad;
    logic [2:0] pay_end;
    logic [7:0] len_byte;

    assign proc_go = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || proc_go;
    assign pay_end  = {1'b0, cfg.expected_length} + 3'd3;
    assign len_byte = {6'd0, cfg.expected_length};

    always_comb begin
        armed_next     = armed_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        acc_next       = acc_reg;
        gap_next       = gap_reg;
        elapsed_next   = elapsed_reg;
        emit           = 1'b0;
        good           = 1'b0;
        bad            = 1'b0;
        m_status_next  = m_status_reg;
        m_payload_next = m_payload_reg;

        if (proc_go) begin
            case (in_cmd_reg)
                CMD_ARM: begin
                    armed_next   = 1'b1;
                    pos_next     = 3'd0;
                    sum_next     = 8'd0;
                    acc_next     = '0;
                    gap_next     = 16'd0;
                    elapsed_next = 16'd0;
                end
                CMD_TICK: begin
                    if (armed_reg) begin
                        if (gap_reg != 16'hFFFF) gap_next = gap_reg + 16'd1;
                        if (elapsed_reg != 16'hFFFF) elapsed_next = elapsed_reg + 16'd1;
                        if (gap_next >= cfg.byte_timeout_ticks) begin
                            emit           = 1'b1;
                            m_status_next  = ST_TIMEOUT;
                            m_payload_next = '0;
                        end
                    end
                end
                CMD_BYTE: begin
                    if (armed_reg) begin
                        gap_next = 16'd0;
                        if (pos_reg == 3'd0) begin
                            if (in_byte_reg == cfg.start_code) begin
                                sum_next = in_byte_reg;
                                acc_next = '0;
                                pos_next = 3'd1;
                            end
                        end else if (pos_reg == 3'd1) begin
                            if (in_byte_reg != cfg.expected_command) begin
                                pos_next = 3'd0;
                            end else begin
                                sum_next = sum_reg + in_byte_reg;
                                pos_next = 3'd2;
                            end
                        end else if (pos_reg == 3'd2) begin
                            if (in_byte_reg != len_byte
                                || len_byte > 8'(MAX_PAYLOAD_BYTES)) begin
                                pos_next = 3'd0;
                            end else begin
                                sum_next = sum_reg + in_byte_reg;
                                pos_next = 3'd3;
                            end
                        end else if (pos_reg < pay_end) begin
                            acc_next = {acc_reg[PAYLOAD_W-9:0], in_byte_reg};
                            sum_next = sum_reg + in_byte_reg;
                            pos_next = pos_reg + 3'd1;
                        end else begin
                            good = (in_byte_reg == sum_reg);
                            bad  = !good;
                        end

                        if (elapsed_reg > cfg.total_timeout_ticks) begin
                            emit           = 1'b1;
                            m_status_next  = ST_TIMEOUT;
                            m_payload_next = '0;
                        end else if (good) begin
                            emit           = 1'b1;
                            m_status_next  = ST_GOOD;
                            m_payload_next = acc_next;
                        end else if (bad) begin
                            emit           = 1'b1;
                            m_status_next  = ST_BADSUM;
                            m_payload_next = '0;
                        end
                    end
                end
                default: ;
            endcase

            if (emit) begin
                armed_next = 1'b0;
                pos_next   = 3'd0;
            end
        end

        m_valid_next = m_valid_reg && !m_ready;
        if (emit) m_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            armed_reg    <= 1'b0;
            pos_reg      <= 3'd0;
            sum_reg      <= 8'd0;
            acc_reg      <= '0;
            gap_reg      <= 16'd0;
            elapsed_reg  <= 16'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) in_valid_reg <= s_valid;
            armed_reg   <= armed_next;
            pos_reg     <= pos_next;
            sum_reg     <= sum_next;
            acc_reg     <= acc_next;
            gap_reg     <= gap_next;
            elapsed_reg <= elapsed_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_cmd_reg  <= cmd_t'(s_command);
            in_byte_reg <= s_rx_byte;
        end
        m_status_reg  <= m_status_next;
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_payload = m_payload_reg;

endmodule

`default_nettype wire

// File: src/rfr_cfg_regs.sv
`default_nettype none

module rfr_cfg_regs
    import rfr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                REG_START_CODE:    cfg_next.start_code          = cfg_wdata[7:0];
                REG_EXP_COMMAND:   cfg_next.expected_command    = cfg_wdata[7:0];
                REG_EXP_LENGTH:    cfg_next.expected_length     = cfg_wdata[1:0];
                REG_BYTE_TIMEOUT:  cfg_next.byte_timeout_ticks  = cfg_wdata;
                REG_TOTAL_TIMEOUT: cfg_next.total_timeout_ticks = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_code          <= RST_START_CODE;
            cfg_reg.expected_command    <= RST_EXP_COMMAND;
            cfg_reg.expected_length     <= RST_EXP_LENGTH;
            cfg_reg.byte_timeout_ticks  <= RST_BYTE_TIMEOUT;
            cfg_reg.total_timeout_ticks <= RST_TOTAL_TIMEOUT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: src/rfr_checker.sv
`default_nettype none

module rfr_checker
    import rfr_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_valid,
    input wire logic                 s_ready,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire logic [1:0]           m_status,
    input wire logic [PAYLOAD_W-1:0] m_payload
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_payload))
        else $error("result beat changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_GOOD || m_status == ST_BADSUM
                     || m_status == ST_TIMEOUT))
        else $error("result status out of range");

    a_fail_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_GOOD |-> m_payload == '0)
        else $error("failed frame carries payload");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready || s_valid || $past(s_valid && s_ready))
        else $error("input stalled with empty output");

endmodule

bind reply_frame_receiver rfr_checker u_rfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_status (m_status),
    .m_payload(m_payload)
);

`default_nettype wire

// File: tb/tb_reply_frame_receiver.sv
module tb_reply_frame_receiver;
    import rfr_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 96;
    localparam int PHASES        = 6;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_TICK_RUN  = 64;

    typedef struct packed {
        cmd_t                 cmd;
        logic [7:0]           data;
        logic                 known;
        logic [1:0]           want_status;
        logic [PAYLOAD_W-1:0] want_payload;
    } beat_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [PAYLOAD_W-1:0] payload;
    } reply_t;

    typedef struct packed {
        logic  is_cfg;
        cfg_t  cfg;
        beat_t beat;
    } plan_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_command = CMD_TICK;
    logic [7:0]            s_rx_byte = 8'h00;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [1:0]            m_status;
    logic [PAYLOAD_W-1:0]  m_payload;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = REG_START_CODE;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    reply_frame_receiver i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_rx_byte (s_rx_byte),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_status  (m_status),
        .m_payload (m_payload),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state and its copy of the registers
    cfg_t                 rx_cfg = {RST_START_CODE, RST_EXP_COMMAND, RST_EXP_LENGTH,
                                    RST_BYTE_TIMEOUT, RST_TOTAL_TIMEOUT};
    logic                 rx_armed   = 1'b0;
    logic [2:0]           rx_pos     = '0;
    logic [7:0]           rx_sum     = '0;
    logic [PAYLOAD_W-1:0] rx_acc     = '0;
    logic [15:0]          rx_gap     = '0;
    logic [15:0]          rx_elapsed = '0;

    plan_row_t stim_plan[$];
    beat_t     tx_beats[$];
    reply_t    awaited_replies[$];
    beat_t     cur_beat = '0;

    logic   in_taken = 1'b0;
    logic   pred_hit;
    reply_t pred_reply;
    reply_t got_reply;
    reply_t want_reply;

    int send_idle_pct = 12;
    int recv_idle_pct = 77;
    int hold_req      = 0;
    int hold_left     = 0;
    int items_queued  = 0;
    int cycle_count   = 0;
    int beats_taken   = 0;
    int cfg_sets      = 0;
    int good_seen     = 0;
    int badsum_seen   = 0;
    int timeout_seen  = 0;
    int errors        = 0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    task automatic report_error(input string what, input logic [31:0] got,
                                input logic [31:0] want);
        errors++;
        $display("ERROR @%0t %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic parse_reply_beat(input logic [1:0] cmd, input logic [7:0] b,
                                    output logic hit, output reply_t rep);
        logic done;
        logic good;
        hit  = 1'b0;
        rep  = '0;
        done = 1'b0;
        good = 1'b0;
        if (cmd == CMD_ARM) begin
            rx_armed   = 1'b1;
            rx_pos     = '0;
            rx_sum     = '0;
            rx_acc     = '0;
            rx_gap     = '0;
            rx_elapsed = '0;
        end else if (rx_armed && cmd == CMD_TICK) begin
            if (rx_gap != 16'hFFFF) rx_gap = rx_gap + 16'd1;
            if (rx_elapsed != 16'hFFFF) rx_elapsed = rx_elapsed + 16'd1;
            if (rx_gap >= rx_cfg.byte_timeout_ticks) begin
                hit        = 1'b1;
                rep.status = ST_TIMEOUT;
            end
        end else if (rx_armed && cmd == CMD_BYTE) begin
            rx_gap = '0;
            if (rx_pos == 3'd0) begin
                if (b == rx_cfg.start_code) begin
                    rx_sum = b;
                    rx_acc = '0;
                    rx_pos = 3'd1;
                end
            end else if (rx_pos == 3'd1) begin
                if (b != rx_cfg.expected_command) begin
                    rx_pos = 3'd0;
                end else begin
                    rx_sum = rx_sum + b;
                    rx_pos = 3'd2;
                end
            end else if (rx_pos == 3'd2) begin
                if (b != {6'd0, rx_cfg.expected_length}) begin
                    rx_pos = 3'd0;
                end else begin
                    rx_sum = rx_sum + b;
                    rx_pos = 3'd3;
                end
            end else if (rx_pos < 3'd3 + rx_cfg.expected_length) begin
                rx_acc = {rx_acc[PAYLOAD_W-9:0], b};
                rx_sum = rx_sum + b;
                rx_pos = rx_pos + 3'd1;
            end else begin
                done = 1'b1;
                good = (b == rx_sum);
            end
            if (rx_elapsed > rx_cfg.total_timeout_ticks) begin
                hit        = 1'b1;
                rep.status = ST_TIMEOUT;
            end else if (done) begin
                hit         = 1'b1;
                rep.status  = good ? ST_GOOD : ST_BADSUM;
                rep.payload = good ? rx_acc : '0;
            end
        end
        if (hit) begin
            rx_armed = 1'b0;
            rx_pos   = '0;
        end
    endtask

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // input beats are predicted on acceptance, results checked in order
    always @(posedge aclk) begin
        in_taken = aresetn && s_valid && s_ready;
        if (in_taken) begin
            parse_reply_beat(s_command, s_rx_byte, pred_hit, pred_reply);
            beats_taken++;
            if (cur_beat.known)
                awaited_replies.push_back({cur_beat.want_status, cur_beat.want_payload});
            else if (pred_hit)
                awaited_replies.push_back(pred_reply);
        end
        if (aresetn && m_valid && m_ready) begin
            got_reply = {m_status, m_payload};
            if (awaited_replies.size() == 0) begin
                report_error("result with none pending", 32'(got_reply), '0);
            end else begin
                want_reply = awaited_replies.pop_front();
                if (got_reply.status !== want_reply.status)
                    report_error("status", 32'(got_reply.status), 32'(want_reply.status));
                if (got_reply.payload !== want_reply.payload)
                    report_error("payload", 32'(got_reply.payload),
                                 32'(want_reply.payload));
                case (want_reply.status)
                    ST_GOOD:    good_seen++;
                    ST_BADSUM:  badsum_seen++;
                    ST_TIMEOUT: timeout_seen++;
                    default:    ;
                endcase
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn && (!s_valid || in_taken)) begin
            if (tx_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                cur_beat = tx_beats.pop_front();
                s_valid   <= 1'b1;
                s_command <= cur_beat.cmd;
                s_rx_byte <= cur_beat.data;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_req != 0) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic row(input cmd_t cmd, input logic [7:0] b);
        plan_row_t r;
        r           = '0;
        r.beat.cmd  = cmd;
        r.beat.data = b;
        stim_plan.push_back(r);
    endtask

    task automatic row_reply(input cmd_t cmd, input logic [7:0] b, input logic [1:0] st,
                             input logic [PAYLOAD_W-1:0] pl);
        plan_row_t r;
        r                   = '0;
        r.beat.cmd          = cmd;
        r.beat.data         = b;
        r.beat.known        = 1'b1;
        r.beat.want_status  = st;
        r.beat.want_payload = pl;
        stim_plan.push_back(r);
    endtask

    task automatic row_cfg(input cfg_t c);
        plan_row_t r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.cfg    = c;
        stim_plan.push_back(r);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
    endtask

    task automatic program_regs(input cfg_t c);
        write_reg(REG_START_CODE, {8'd0, c.start_code});
        write_reg(REG_EXP_COMMAND, {8'd0, c.expected_command});
        write_reg(REG_EXP_LENGTH, {14'd0, c.expected_length});
        write_reg(REG_BYTE_TIMEOUT, c.byte_timeout_ticks);
        write_reg(REG_TOTAL_TIMEOUT, c.total_timeout_ticks);
        @(negedge aclk);
        cfg_we <= 1'b0;
        rx_cfg = c;
        cfg_sets++;
    endtask

    task automatic settle();
        while (tx_beats.size() != 0 || s_valid || awaited_replies.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_beat(input cmd_t cmd, input logic [7:0] b);
        beat_t bt;
        bt      = '0;
        bt.cmd  = cmd;
        bt.data = b;
        tx_beats.push_back(bt);
        if (cmd != CMD_RSVD) items_queued++;
    endtask

    task automatic queue_frame_byte(input logic [7:0] b);
        queue_beat(CMD_BYTE, b);
        if ($urandom_range(99) < 20)
            repeat ($urandom_range(1, 3)) queue_beat(CMD_TICK, rand_byte());
    endtask

    // one frame, mostly after an arm, with occasional corruption, tick runs or plain noise
    task automatic queue_exchange();
        int         roll;
        int         n;
        int         i;
        logic [7:0] sum;
        logic [7:0] b;
        logic [7:0] flip;
        roll = $urandom_range(99);
        flip = 8'($urandom_range(1, 255));
        if (roll < 8) begin
            repeat ($urandom_range(2, 6)) queue_beat(cmd_t'($urandom_range(3)), rand_byte());
        end else begin
            if (roll < 95) queue_beat(CMD_ARM, rand_byte());
            repeat ($urandom_range(2)) queue_beat(CMD_BYTE, rand_byte());
            if (roll < 16) begin
                n = int'(rx_cfg.byte_timeout_ticks);
                if (n > MAX_TICK_RUN) n = MAX_TICK_RUN;
                repeat (n) queue_beat(CMD_TICK, rand_byte());
            end
            sum = rx_cfg.start_code;
            queue_frame_byte(rx_cfg.start_code);
            b = rx_cfg.expected_command;
            if (roll >= 16 && roll < 22) b = b ^ flip;
            sum = sum + b;
            queue_frame_byte(b);
            b = {6'd0, rx_cfg.expected_length};
            if (roll >= 22 && roll < 28) b = b ^ flip;
            sum = sum + b;
            queue_frame_byte(b);
            for (i = 0; i < rx_cfg.expected_length; i++) begin
                b   = rand_byte();
                sum = sum + b;
                queue_frame_byte(b);
            end
            if (roll >= 28 && roll < 40) sum = sum ^ flip;
            queue_frame_byte(sum);
        end
    endtask

    initial begin : main_seq
        cfg_t c;
        int   p;

        // reset config
        row(CMD_BYTE, 8'hAA);
        row(CMD_TICK, 8'h00);
        row(CMD_RSVD, 8'hFF);
        row(CMD_ARM,  8'h00);
        row(CMD_BYTE, 8'hAA);
        row(CMD_BYTE, 8'hAA);
        row(CMD_BYTE, 8'hAA);
        row(CMD_BYTE, 8'h01);
        row(CMD_BYTE, 8'h02);
        row(CMD_BYTE, 8'hAA);
        row(CMD_BYTE, 8'h01);
        row(CMD_ARM,  8'hFF);
        row(CMD_BYTE, 8'hAA);
        row(CMD_BYTE, 8'h01);
        row(CMD_BYTE, 8'h01);
        row(CMD_BYTE, 8'hFF);
        row_reply(CMD_BYTE, 8'h00, ST_BADSUM, '0);
        row(CMD_TICK, 8'h00);
        row_cfg({8'h00, 8'hFF, 2'd3, 16'd1, 16'hFFFF});
        row(CMD_ARM,  8'h00);
        row_reply(CMD_TICK, 8'h00, ST_TIMEOUT, '0);
        row(CMD_ARM,  8'h00);
        row(CMD_BYTE, 8'h00);
        row(CMD_BYTE, 8'hFF);
        row(CMD_BYTE, 8'h03);
        row(CMD_BYTE, 8'hFF);
        row(CMD_BYTE, 8'hFF);
        row(CMD_BYTE, 8'hFF);
        row_reply(CMD_BYTE, 8'hFF, ST_GOOD, 24'hFFFFFF);
        // zero-length frame, then total timeout landing on the checksum byte
        row_cfg({8'hFF, 8'h00, 2'd0, 16'hFFFF, 16'd1});
        row(CMD_ARM,  8'h00);
        row(CMD_BYTE, 8'hFF);
        row(CMD_BYTE, 8'h00);
        row(CMD_BYTE, 8'h00);
        row_reply(CMD_BYTE, 8'hFF, ST_GOOD, '0);
        row(CMD_ARM,  8'h00);
        row(CMD_BYTE, 8'hFF);
        row(CMD_BYTE, 8'h00);
        row(CMD_BYTE, 8'h00);
        row(CMD_TICK, 8'h00);
        row(CMD_TICK, 8'h00);
        row_reply(CMD_BYTE, 8'hFF, ST_TIMEOUT, '0);

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (stim_plan[i]) begin
            if (stim_plan[i].is_cfg) begin
                settle();
                program_regs(stim_plan[i].cfg);
            end else begin
                tx_beats.push_back(stim_plan[i].beat);
            end
        end

        for (p = 0; p < PHASES; p++) begin
            settle();
            send_idle_pct = (p < 2) ? 12 : (p < 4) ? 77 : 0;
            recv_idle_pct = (p < 2) ? 77 : (p < 4) ? 12 : 0;
            c.start_code          = rand_byte();
            c.expected_command    = (p == 2) ? c.start_code : rand_byte();
            c.expected_length     = 2'($urandom_range(3));
            c.byte_timeout_ticks  = (p == 3) ? 16'hFFFF : 16'($urandom_range(3, 24));
            c.total_timeout_ticks = (p == 5) ? 16'hFFFF : 16'($urandom_range(8, 60));
            program_regs(c);
            if (p == 4) hold_req = 1;
            items_queued = 0;
            while (items_queued < PHASE_ITEMS) queue_exchange();
        end
        settle();

        $display("covered %0d input beats under %0d register settings, incl. a long result stall",
                 beats_taken, cfg_sets);
        $display("results: %0d good, %0d bad checksum, %0d timeout; %0d errors",
                 good_seen, badsum_seen, timeout_seen, errors);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
